// File: rtl/core/hrgb_pkg.sv
package hrgb_pkg;

   // Field and port widths.
   localparam int IterW    = 16;
   localparam int HueW     = 9;
   localparam int ChanW    = 8;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 16;

   // Register indexes on the configuration port.
   localparam logic [CsrIdxW-1:0] CSR_MAX_ITER  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_HUE_SHIFT = 2'd1;

   // Register reset values.
   localparam logic [IterW-1:0] MAX_ITER_RESET  = 16'd64;
   localparam logic [HueW-1:0]  HUE_SHIFT_RESET = 9'd0;

   // Angles in degrees.
   localparam logic [HueW-1:0] DEG_60  = 9'd60;
   localparam logic [HueW-1:0] DEG_120 = 9'd120;
   localparam logic [HueW-1:0] DEG_180 = 9'd180;
   localparam logic [HueW-1:0] DEG_240 = 9'd240;
   localparam logic [HueW-1:0] DEG_300 = 9'd300;
   localparam logic [HueW-1:0] DEG_360 = 9'd360;

   localparam logic [ChanW-1:0] FULL_SCALE = 8'd255;

   // The iteration hue is 5*count, so only count mod 72 matters for the
   // angle.  floor(count/72) is count*58255 >> 22, exact for 16-bit counts.
   localparam logic [15:0] MOD72_RECIP = 16'd58255;
   localparam int          Mod72Shift  = 22;
   localparam int          Mod72QW     = 32 - Mod72Shift;

   // floor(n/60) is n*17477 >> 20, exact for n up to 255*60.
   localparam logic [14:0] DIV60_RECIP = 15'd17477;
   localparam int          Div60Shift  = 20;

   // Sixty-degree hue sectors.
   localparam logic [2:0] SEC_RED_YELLOW   = 3'd0;
   localparam logic [2:0] SEC_YELLOW_GREEN = 3'd1;
   localparam logic [2:0] SEC_GREEN_CYAN   = 3'd2;
   localparam logic [2:0] SEC_CYAN_BLUE    = 3'd3;
   localparam logic [2:0] SEC_BLUE_MAGENTA = 3'd4;
   localparam logic [2:0] SEC_MAGENTA_RED  = 3'd5;

   localparam int PipeDepth = 8;

endpackage

// File: rtl/core/hsv_to_rgb_pixel_colour.sv
// HSV to RGB pixel colour converter.  Each request transaction carries one
// pixel: in mode 0 a hue in degrees with 8-bit saturation and value, in
// mode 1 an escape-iteration count that is coloured black when it equals
// max_iterations (register 0) and otherwise at full saturation and value
// with hue (5*count + hue_shift) mod 360 (hue_shift is register 1).  The
// converter is an eight-stage pipeline: it takes one pixel per clock while
// nothing stalls.  Each stage holds its pixel while the stage after it is
// full and stalled, so bubbles are squeezed out and the input keeps flowing
// until every stage is full.  Stage depth is set by the multipliers: one
// 16x16 reciprocal multiply for the hue wrap, v*s, c*w and one reciprocal
// multiply by 1/60, each in a stage of its own.  Configuration must be
// written only while idle; the block itself does not enforce this.
module hsv_to_rgb_pixel_colour
   import hrgb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_mode,
   input  logic [HueW-1:0]     req_hue_degrees,
   input  logic [ChanW-1:0]    req_saturation_level,
   input  logic [ChanW-1:0]    req_value_level,
   input  logic [IterW-1:0]    req_iteration_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ChanW-1:0]    rsp_red,
   output logic [ChanW-1:0]    rsp_green,
   output logic [ChanW-1:0]    rsp_blue,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   // Configuration registers.
   logic [IterW-1:0] max_iter_ff;
   logic [HueW-1:0]  hue_shift_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff  <= MAX_ITER_RESET;
         hue_shift_ff <= HUE_SHIFT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_ITER:  max_iter_ff  <= csr_wdata[IterW-1:0];
            CSR_HUE_SHIFT: hue_shift_ff <= csr_wdata[HueW-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline flow control: a stage loads when it is empty or its content
   // moves on.
   logic [PipeDepth-1:0] valid_ff;
   logic [PipeDepth-1:0] valid_in;
   logic [PipeDepth-1:0] move;

   always_comb begin
      move[PipeDepth-1] = !valid_ff[PipeDepth-1] || !rsp_stall;
      for (int k = PipeDepth - 2; k >= 0; k--) begin
         move[k] = !valid_ff[k] || move[k+1];
      end
      valid_in[0] = move[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < PipeDepth; k++) begin
         valid_in[k] = move[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !move[0];
   assign rsp_valid = valid_ff[PipeDepth-1];

   // Stage 0: wrap the direct hue and the shift, test for black and start
   // the count mod 72 reduction.
   logic             a_mode_ff;
   logic [HueW-1:0]  a_hue_ff;
   logic [ChanW-1:0] a_sat_ff;
   logic [ChanW-1:0] a_val_ff;
   logic [IterW-1:0] a_cnt_ff;
   logic [31:0]      a_prod_ff;
   logic [HueW-1:0]  a_shift_ff;
   logic             a_black_ff;
   logic [HueW-1:0]  a_hue_in;
   logic [HueW-1:0]  a_shift_in;
   logic [31:0]      a_prod_in;

   always_comb begin
      a_hue_in   = (req_hue_degrees >= DEG_360) ? req_hue_degrees - DEG_360
                                                : req_hue_degrees;
      a_shift_in = (hue_shift_ff >= DEG_360) ? hue_shift_ff - DEG_360 : hue_shift_ff;
      a_prod_in  = req_iteration_count * MOD72_RECIP;
   end

   always_ff @(posedge clock) begin
      if (move[0]) begin
         a_mode_ff  <= req_mode;
         a_hue_ff   <= a_hue_in;
         a_sat_ff   <= req_saturation_level;
         a_val_ff   <= req_value_level;
         a_cnt_ff   <= req_iteration_count;
         a_prod_ff  <= a_prod_in;
         a_shift_ff <= a_shift_in;
         a_black_ff <= req_mode && (req_iteration_count == max_iter_ff);
      end
   end

   // Stage 1: remainder of the count modulo 72.
   logic             b_mode_ff;
   logic [HueW-1:0]  b_hue_ff;
   logic [ChanW-1:0] b_sat_ff;
   logic [ChanW-1:0] b_val_ff;
   logic [6:0]       b_rem_ff;
   logic [HueW-1:0]  b_shift_ff;
   logic             b_black_ff;
   logic [Mod72QW-1:0] b_quot;
   logic [16:0]      b_diff;

   always_comb begin
      b_quot = a_prod_ff[31:Mod72Shift];
      b_diff = {1'b0, a_cnt_ff} - {1'b0, b_quot, 6'b0} - {4'b0, b_quot, 3'b0};
   end

   always_ff @(posedge clock) begin
      if (move[1]) begin
         b_mode_ff  <= a_mode_ff;
         b_hue_ff   <= a_hue_ff;
         b_sat_ff   <= a_sat_ff;
         b_val_ff   <= a_val_ff;
         b_rem_ff   <= b_diff[6:0];
         b_shift_ff <= a_shift_ff;
         b_black_ff <= a_black_ff;
      end
   end

   // Stage 2: final hue, saturation and value for either mode.
   logic [HueW-1:0]  c_hue_ff;
   logic [ChanW-1:0] c_sat_ff;
   logic [ChanW-1:0] c_val_ff;
   logic             c_black_ff;
   logic [9:0]       c_sum;
   logic [HueW-1:0]  c_iter_hue;

   always_comb begin
      c_sum      = {1'b0, b_rem_ff, 2'b0} + {3'b0, b_rem_ff} + {1'b0, b_shift_ff};
      c_iter_hue = (c_sum >= {1'b0, DEG_360}) ? HueW'(c_sum - {1'b0, DEG_360})
                                              : c_sum[HueW-1:0];
   end

   always_ff @(posedge clock) begin
      if (move[2]) begin
         c_hue_ff   <= b_mode_ff ? c_iter_hue : b_hue_ff;
         c_sat_ff   <= b_mode_ff ? FULL_SCALE : b_sat_ff;
         c_val_ff   <= b_mode_ff ? FULL_SCALE : b_val_ff;
         c_black_ff <= b_black_ff;
      end
   end

   // Stage 3: v*s, the sector and the ramp weight 60 - |(h mod 120) - 60|.
   logic [15:0]      d_prod_ff;
   logic [ChanW-1:0] d_val_ff;
   logic [2:0]       d_sector_ff;
   logic [5:0]       d_weight_ff;
   logic             d_black_ff;
   logic [2:0]       d_sector_in;
   logic [HueW-1:0]  d_tri;
   logic [HueW-1:0]  d_weight;

   always_comb begin
      if (c_hue_ff < DEG_60) begin
         d_sector_in = SEC_RED_YELLOW;
      end else if (c_hue_ff < DEG_120) begin
         d_sector_in = SEC_YELLOW_GREEN;
      end else if (c_hue_ff < DEG_180) begin
         d_sector_in = SEC_GREEN_CYAN;
      end else if (c_hue_ff < DEG_240) begin
         d_sector_in = SEC_CYAN_BLUE;
      end else if (c_hue_ff < DEG_300) begin
         d_sector_in = SEC_BLUE_MAGENTA;
      end else begin
         d_sector_in = SEC_MAGENTA_RED;
      end
      if (c_hue_ff >= DEG_240) begin
         d_tri = c_hue_ff - DEG_240;
      end else if (c_hue_ff >= DEG_120) begin
         d_tri = c_hue_ff - DEG_120;
      end else begin
         d_tri = c_hue_ff;
      end
      d_weight = (d_tri >= DEG_60) ? DEG_120 - d_tri : d_tri;
   end

   always_ff @(posedge clock) begin
      if (move[3]) begin
         d_prod_ff   <= c_val_ff * c_sat_ff;
         d_val_ff    <= c_val_ff;
         d_sector_ff <= d_sector_in;
         d_weight_ff <= d_weight[5:0];
         d_black_ff  <= c_black_ff;
      end
   end

   // Stage 4: chroma c = floor(v*s/255) and offset m = v - c.
   logic [ChanW-1:0] e_chroma_ff;
   logic [ChanW-1:0] e_offset_ff;
   logic [2:0]       e_sector_ff;
   logic [5:0]       e_weight_ff;
   logic             e_black_ff;
   logic [16:0]      e_div_sum;
   logic [ChanW-1:0] e_chroma;

   always_comb begin
      e_div_sum = {1'b0, d_prod_ff} + {9'b0, d_prod_ff[15:8]} + 17'd1;
      e_chroma  = e_div_sum[15:8];
   end

   always_ff @(posedge clock) begin
      if (move[4]) begin
         e_chroma_ff <= e_chroma;
         e_offset_ff <= d_val_ff - e_chroma;
         e_sector_ff <= d_sector_ff;
         e_weight_ff <= d_weight_ff;
         e_black_ff  <= d_black_ff;
      end
   end

   // Stage 5: c times the ramp weight.
   logic [13:0]      f_scaled_ff;
   logic [ChanW-1:0] f_chroma_ff;
   logic [ChanW-1:0] f_offset_ff;
   logic [2:0]       f_sector_ff;
   logic             f_black_ff;

   always_ff @(posedge clock) begin
      if (move[5]) begin
         f_scaled_ff <= e_chroma_ff * e_weight_ff;
         f_chroma_ff <= e_chroma_ff;
         f_offset_ff <= e_offset_ff;
         f_sector_ff <= e_sector_ff;
         f_black_ff  <= e_black_ff;
      end
   end

   // Stage 6: second component x = floor(c*w/60).
   logic [ChanW-1:0] g_second_ff;
   logic [ChanW-1:0] g_chroma_ff;
   logic [ChanW-1:0] g_offset_ff;
   logic [2:0]       g_sector_ff;
   logic             g_black_ff;
   logic [28:0]      g_prod;

   assign g_prod = f_scaled_ff * DIV60_RECIP;

   always_ff @(posedge clock) begin
      if (move[6]) begin
         g_second_ff <= g_prod[Div60Shift+ChanW-1:Div60Shift];
         g_chroma_ff <= f_chroma_ff;
         g_offset_ff <= f_offset_ff;
         g_sector_ff <= f_sector_ff;
         g_black_ff  <= f_black_ff;
      end
   end

   // Stage 7: place c and x by sector and lift every channel by m, or give black.
   logic [ChanW-1:0] out_red_ff;
   logic [ChanW-1:0] out_green_ff;
   logic [ChanW-1:0] out_blue_ff;
   logic [ChanW-1:0] h_red;
   logic [ChanW-1:0] h_green;
   logic [ChanW-1:0] h_blue;

   always_comb begin
      case (g_sector_ff)
         SEC_RED_YELLOW: begin
            h_red = g_chroma_ff; h_green = g_second_ff; h_blue = '0;
         end
         SEC_YELLOW_GREEN: begin
            h_red = g_second_ff; h_green = g_chroma_ff; h_blue = '0;
         end
         SEC_GREEN_CYAN: begin
            h_red = '0; h_green = g_chroma_ff; h_blue = g_second_ff;
         end
         SEC_CYAN_BLUE: begin
            h_red = '0; h_green = g_second_ff; h_blue = g_chroma_ff;
         end
         SEC_BLUE_MAGENTA: begin
            h_red = g_second_ff; h_green = '0; h_blue = g_chroma_ff;
         end
         default: begin
            h_red = g_chroma_ff; h_green = '0; h_blue = g_second_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (move[7]) begin
         out_red_ff   <= g_black_ff ? '0 : h_red + g_offset_ff;
         out_green_ff <= g_black_ff ? '0 : h_green + g_offset_ff;
         out_blue_ff  <= g_black_ff ? '0 : h_blue + g_offset_ff;
      end
   end

   assign rsp_red   = out_red_ff;
   assign rsp_green = out_green_ff;
   assign rsp_blue  = out_blue_ff;

endmodule

// File: rtl/core/hrgb_checker.sv
module hrgb_checker
   import hrgb_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [ChanW-1:0]    rsp_red,
   input logic [ChanW-1:0]    rsp_green,
   input logic [ChanW-1:0]    rsp_blue
);

   // The pipeline is empty right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result transaction holds its colour.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red)
                                 && $stable(rsp_green) && $stable(rsp_blue))
      else $error("stalled result changed");

   // With the output stage empty, every stage can move, so input is open.
   assert property (@(posedge clock) !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output stage");

   // An output that drains lets the whole pipeline advance.
   assert property (@(posedge clock) !rsp_stall |-> !req_stall)
      else $error("input stalled while output drains");

endmodule

bind hsv_to_rgb_pixel_colour hrgb_checker u_hrgb_checker (.*);
